FILE: design/dsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsm_pkg
// shared constants, types and the arctangent table of the steering mixer
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam int unsigned DefCoordWidth = 16;
    localparam int unsigned DefCordicSteps = 16;

    localparam int unsigned ZW = 35;  // angle width, q2.30 with headroom
    localparam int unsigned SW = 34;  // sine datapath width, q2.30
    localparam int unsigned CW = 2;   // config index width

    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [SW-1:0] INV_GAIN    = 34'sd652032875;

    localparam logic [CW-1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [CW-1:0] REG_TURN_GAIN = 2'd1;

    typedef struct packed {
        logic fwd;
        logic neg;
        logic pos;
    } t_side;

    function automatic logic [30:0] atan_q30(input logic [4:0] i);
        logic [30:0] v;
        unique case (i)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048576;
            5'd11: v = 31'd524288;
            5'd12: v = 31'd262144;
            5'd13: v = 31'd131072;
            5'd14: v = 31'd65536;
            5'd15: v = 31'd32768;
            5'd16: v = 31'd16384;
            5'd17: v = 31'd8192;
            5'd18: v = 31'd4096;
            5'd19: v = 31'd2048;
            5'd20: v = 31'd1024;
            5'd21: v = 31'd512;
            5'd22: v = 31'd256;
            5'd23: v = 31'd128;
            5'd24: v = 31'd64;
            5'd25: v = 31'd32;
            5'd26: v = 31'd16;
            5'd27: v = 31'd8;
            5'd28: v = 31'd4;
            5'd29: v = 31'd2;
            5'd30: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/differential_steer_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// differential_steer_mixer
// turns a move vector and the present speed into wheel directions and speeds
//
// input channel: i_in_valid / o_in_stall with move_x, move_y, current_speed.
// output channel: o_out_valid / i_out_stall with direction flags and speeds.
// config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 max_speed,
// 1 turn_gain); the user must write only while no item is in flight, as the
// block does not enforce it. one item enters and one result leaves per cycle
// unless the output stalls. the path from the accepting edge to o_out_valid
// runs through the input register, one stage per vectoring cordic step, a
// rounding stage, one per sine cordic step, then magnitude, ratio, split
// product, product sum and output stages.
// reset empties the pipeline and loads max_speed 100, turn_gain 19661.
// when the receiver stalls a waiting result, the whole pipeline holds and
// o_in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module differential_steer_mixer
    import dsm_pkg::*;
#(
    parameter int unsigned COORD_WIDTH  = DefCoordWidth,
    parameter int unsigned CORDIC_STEPS = DefCordicSteps
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CW-1:0]        i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic signed [15:0]   i_move_x,
    input  wire logic signed [15:0]   i_move_y,
    input  wire logic signed [15:0]   i_current_speed,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_left_forward,
    output logic [15:0]               o_left_speed,
    output logic                      o_right_forward,
    output logic [15:0]               o_right_speed
);

    localparam int unsigned AW = COORD_WIDTH + 3;
    localparam int unsigned N  = CORDIC_STEPS;

    logic [15:0] r_max_speed;
    logic [15:0] r_turn_gain;
    logic        adv;

    // vectoring pipeline
    logic signed [AW-1:0] r_va [0:N];
    logic signed [AW-1:0] r_vb [0:N];
    logic signed [ZW-1:0] r_vz [0:N];
    logic                 r_vbyp [0:N];
    logic                 r_vfwd [0:N];
    logic                 r_vv [0:N];
    logic signed [AW-1:0] n_va [1:N];
    logic signed [AW-1:0] n_vb [1:N];
    logic signed [ZW-1:0] n_vz [1:N];

    // sine pipeline
    logic signed [SW-1:0] r_sx [0:N];
    logic signed [SW-1:0] r_sy [0:N];
    logic signed [ZW-1:0] r_sz [0:N];
    logic signed [15:0]   r_sa [0:N];
    logic                 r_sfwd [0:N];
    logic                 r_sv [0:N];
    logic signed [SW-1:0] n_sx [1:N];
    logic signed [SW-1:0] n_sy [1:N];
    logic signed [ZW-1:0] n_sz [1:N];

    logic signed [AW-1:0] n_a0;
    logic signed [AW-1:0] n_b0;
    logic signed [ZW-1:0] n_z0;
    logic                 n_byp0;
    logic signed [15:0]   den;
    logic signed [47:0]   sc_den;
    logic signed [47:0]   sc_num;

    logic signed [ZW-1:0] zc;
    logic signed [ZW-1:0] zr;
    logic signed [15:0]   n_a13;

    t_side        r_p1_side, r_p2_side, r_p3_side, r_p4_side;
    logic         r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_ov;
    logic [31:0]  r_m1;
    logic [16:0]  r_s15;
    logic [45:0]  r_ratio;
    logic [38:0]  r_plo;
    logic [38:0]  r_phi;
    logic [61:0]  r_prod;
    logic [SW-1:0] ys_abs;
    logic [SW-1:0] ys_rnd;
    logic [16:0]  n_s15;
    logic [15:0]  n_mag;
    logic [18:0]  cut;
    logic [15:0]  slow;
    logic         r_ofwd;
    logic [15:0]  r_oleft;
    logic [15:0]  r_oright;

    assign adv        = !(r_ov && i_out_stall);
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= 16'd100;
            r_turn_gain <= 16'd19661;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MAX_SPEED) begin
                r_max_speed <= i_cfg_data;
            end else if (i_cfg_index == REG_TURN_GAIN) begin
                r_turn_gain <= i_cfg_data;
            end
        end
    end

    // input stage: special cases, scaling and half-plane fold
    always_comb begin
        den    = (i_move_y > i_current_speed) ? i_current_speed : i_move_y;
        sc_den = 48'(den);
        sc_num = 48'(i_move_x);
        if (COORD_WIDTH >= 16) begin
            sc_den = sc_den <<< (COORD_WIDTH - 16);
            sc_num = sc_num <<< (COORD_WIDTH - 16);
        end else begin
            sc_den = sc_den >>> (16 - COORD_WIDTH);
            sc_num = sc_num >>> (16 - COORD_WIDTH);
        end
        n_a0   = sc_den[AW-1:0];
        n_b0   = sc_num[AW-1:0];
        n_z0   = '0;
        n_byp0 = 1'b0;
        if (i_move_y == 16'sd0 && i_move_x != 16'sd0) begin
            n_byp0 = 1'b1;
        end else if (i_move_x == 16'sd0) begin
            n_byp0 = 1'b1;
            n_z0   = (den < 16'sd0) ? PI_Q30 : '0;
        end else if (den == 16'sd0) begin
            n_byp0 = 1'b1;
            n_z0   = (i_move_x > 16'sd0) ? HALF_PI_Q30 : -HALF_PI_Q30;
        end else if (den < 16'sd0) begin
            n_a0 = -n_a0;
            n_b0 = -n_b0;
            n_z0 = (i_move_x > 16'sd0) ? PI_Q30 : -PI_Q30;
        end
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (r_vbyp[k]) begin
                n_va[k+1] = r_va[k];
                n_vb[k+1] = r_vb[k];
                n_vz[k+1] = r_vz[k];
            end else if (r_vb[k] > 0) begin
                n_va[k+1] = r_va[k] + (r_vb[k] >>> k);
                n_vb[k+1] = r_vb[k] - (r_va[k] >>> k);
                n_vz[k+1] = r_vz[k] + ZW'(atan_q30(5'(k)));
            end else begin
                n_va[k+1] = r_va[k] - (r_vb[k] >>> k);
                n_vb[k+1] = r_vb[k] + (r_va[k] >>> k);
                n_vz[k+1] = r_vz[k] - ZW'(atan_q30(5'(k)));
            end
        end
    end

    // clamp, round to q3.13 and start the half-angle sine
    always_comb begin
        zc = r_vz[N];
        if (zc > PI_Q30) begin
            zc = PI_Q30;
        end else if (zc < -PI_Q30) begin
            zc = -PI_Q30;
        end
        zr    = zc + ZW'(65536);
        n_a13 = 16'(zr >>> 17);
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (r_sz[k] >= 0) begin
                n_sx[k+1] = r_sx[k] - (r_sy[k] >>> k);
                n_sy[k+1] = r_sy[k] + (r_sx[k] >>> k);
                n_sz[k+1] = r_sz[k] - ZW'(atan_q30(5'(k)));
            end else begin
                n_sx[k+1] = r_sx[k] + (r_sy[k] >>> k);
                n_sy[k+1] = r_sy[k] - (r_sx[k] >>> k);
                n_sz[k+1] = r_sz[k] + ZW'(atan_q30(5'(k)));
            end
        end
    end

    always_comb begin
        ys_abs = r_sy[N][SW-1] ? SW'(-r_sy[N]) : SW'(r_sy[N]);
        ys_rnd = (ys_abs + SW'(16384)) >> 15;
        n_s15  = (ys_rnd > SW'(32768)) ? 17'd32768 : ys_rnd[16:0];
        n_mag  = r_sa[N][15] ? 16'(-r_sa[N]) : 16'(r_sa[N]);
        cut    = 19'(r_prod[61:44]) + 19'(|r_prod[43:0]);
        slow   = (19'(r_max_speed) > cut) ? (r_max_speed - cut[15:0]) : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_va[0]   <= n_a0;
            r_vb[0]   <= n_b0;
            r_vz[0]   <= n_z0;
            r_vbyp[0] <= n_byp0;
            r_vfwd[0] <= (i_move_y > 16'sd0);
            for (int k = 0; k < N; k++) begin
                r_va[k+1]   <= n_va[k+1];
                r_vb[k+1]   <= n_vb[k+1];
                r_vz[k+1]   <= n_vz[k+1];
                r_vbyp[k+1] <= r_vbyp[k];
                r_vfwd[k+1] <= r_vfwd[k];
            end
            r_sx[0]   <= INV_GAIN;
            r_sy[0]   <= '0;
            r_sz[0]   <= ZW'(n_a13) <<< 16;
            r_sa[0]   <= n_a13;
            r_sfwd[0] <= r_vfwd[N];
            for (int k = 0; k < N; k++) begin
                r_sx[k+1]   <= n_sx[k+1];
                r_sy[k+1]   <= n_sy[k+1];
                r_sz[k+1]   <= n_sz[k+1];
                r_sa[k+1]   <= r_sa[k];
                r_sfwd[k+1] <= r_sfwd[k];
            end
            r_p1_side <= '{fwd: r_sfwd[N], neg: r_sa[N] < 16'sd0, pos: r_sa[N] > 16'sd0};
            r_m1      <= 32'(n_mag) * 32'(r_turn_gain);
            r_s15     <= n_s15;
            r_p2_side <= r_p1_side;
            r_ratio   <= 46'(49'(r_m1) * 49'(r_s15));
            r_p3_side <= r_p2_side;
            r_plo     <= 39'(r_max_speed) * 39'(r_ratio[22:0]);
            r_phi     <= 39'(r_max_speed) * 39'(r_ratio[45:23]);
            r_p4_side <= r_p3_side;
            r_prod    <= {r_phi, 23'd0} + 62'(r_plo);
            r_ofwd    <= r_p4_side.fwd;
            r_oleft   <= r_p4_side.neg ? slow : r_max_speed;
            r_oright  <= r_p4_side.pos ? slow : r_max_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_vv[k] <= 1'b0;
                r_sv[k] <= 1'b0;
            end
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (adv) begin
            r_vv[0] <= i_in_valid;
            for (int k = 0; k < N; k++) begin
                r_vv[k+1] <= r_vv[k];
                r_sv[k+1] <= r_sv[k];
            end
            r_sv[0] <= r_vv[N];
            r_p1_v  <= r_sv[N];
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_p4_v  <= r_p3_v;
            r_ov    <= r_p4_v;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_left_forward  = r_ofwd;
    assign o_right_forward = r_ofwd;
    assign o_left_speed    = r_oleft;
    assign o_right_speed   = r_oright;

    a_one_side_slowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_speed == r_max_speed || o_right_speed == r_max_speed))
        else $error("both wheels slowed");

    a_no_speedup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_speed <= r_max_speed && o_right_speed <= r_max_speed))
        else $error("wheel faster than full speed");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_p4_v) && $stable(r_vv[0]))
        else $error("pipeline moved while held");

endmodule
`default_nettype wire

FILE: sim/tb_differential_steer_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_differential_steer_mixer
// self-checking bench for the steering mixer: a table of directed moves, then
// random moves under three idling patterns and a long output hold-off; every
// result is compared with a bit-true model of both cordics and the speed cut
// ----------------------------------------------------------------------------
module tb_differential_steer_mixer;
    import dsm_pkg::*;

    localparam int Latency = 2 * DefCordicSteps + 6;
    localparam int CycleLimit = 400000;
    localparam longint PiQ30 = 64'sd3373259426;
    localparam longint HalfPiQ30 = 64'sd1686629713;
    localparam longint InvGainQ30 = 64'sd652032875;

    typedef struct packed {
        logic        lfwd;
        logic [15:0] lspd;
        logic        rfwd;
        logic [15:0] rspd;
    } t_wheels;

    typedef struct {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] cs;
        logic               typed;
        t_wheels            want;
    } t_move_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CW-1:0]      i_cfg_index = REG_MAX_SPEED;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_move_x = '0;
    logic signed [15:0] i_move_y = '0;
    logic signed [15:0] i_current_speed = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_left_forward;
    logic [15:0]        o_left_speed;
    logic               o_right_forward;
    logic [15:0]        o_right_speed;

    differential_steer_mixer dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    longint  mdl_max_speed;
    longint  mdl_turn_gain;
    t_wheels wheels_due[$];
    int      err_count = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_off = 0;
    longint  angle_tab[32];

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint cordic_angle(longint num, longint den);
        longint a, b, z, na, nb;
        z = 0;
        if (num == 0) return den < 0 ? PiQ30 : 0;
        if (den == 0) return num > 0 ? HalfPiQ30 : -HalfPiQ30;
        a = den;
        b = num;
        if (a < 0) begin
            a = -a;
            b = -b;
            z = num > 0 ? PiQ30 : -PiQ30;
        end
        for (int i = 0; i < DefCordicSteps; i++) begin
            if (b > 0) begin
                na = a + fshr(b, i);
                nb = b - fshr(a, i);
                z += angle_tab[i];
            end else begin
                na = a - fshr(b, i);
                nb = b + fshr(a, i);
                z -= angle_tab[i];
            end
            a = na;
            b = nb;
        end
        if (z > PiQ30) z = PiQ30;
        if (z < -PiQ30) z = -PiQ30;
        return z;
    endfunction

    function automatic longint half_sine_q15(longint z);
        longint x, y, nx, ny, s;
        x = InvGainQ30;
        y = 0;
        for (int i = 0; i < DefCordicSteps; i++) begin
            if (z >= 0) begin
                nx = x - fshr(y, i);
                ny = y + fshr(x, i);
                z -= angle_tab[i];
            end else begin
                nx = x + fshr(y, i);
                ny = y - fshr(x, i);
                z += angle_tab[i];
            end
            x = nx;
            y = ny;
        end
        s = y < 0 ? -y : y;
        s = (s + 16384) >>> 15;
        if (s > 32768) s = 32768;
        return s;
    endfunction

    function automatic t_wheels mix_wheels(logic signed [15:0] mx, logic signed [15:0] my,
                                           logic signed [15:0] cs);
        t_wheels w;
        longint den, a13, mag, s15, cut, slow;
        logic [127:0] prod;
        w.lfwd = my > 0;
        w.rfwd = my > 0;
        w.lspd = mdl_max_speed[15:0];
        w.rspd = mdl_max_speed[15:0];
        if (!(my == 0 && mx != 0)) begin
            den = my > cs ? cs : my;
            a13 = fshr(cordic_angle(mx, den) + 65536, 17);
            mag = a13 < 0 ? -a13 : a13;
            s15 = half_sine_q15(a13 * 65536);
            prod = 128'(mdl_max_speed) * 128'(mag) * 128'(mdl_turn_gain) * 128'(s15);
            cut = longint'(prod >> 44) + ((prod[43:0] != 0) ? 1 : 0);
            slow = mdl_max_speed > cut ? mdl_max_speed - cut : 0;
            if (a13 < 0) w.lspd = slow[15:0];
            else if (a13 > 0) w.rspd = slow[15:0];
        end
        return w;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    task automatic write_reg(logic [CW-1:0] idx, logic [15:0] val);
        repeat (Latency + 2) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_MAX_SPEED) mdl_max_speed = val;
        else if (idx == REG_TURN_GAIN) mdl_turn_gain = val;
    endtask

    task automatic send_move(logic signed [15:0] mx, logic signed [15:0] my,
                             logic signed [15:0] cs, logic typed, t_wheels want);
        t_wheels w;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_move_x = mx;
        i_move_y = my;
        i_current_speed = cs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        w = mix_wheels(mx, my, cs);
        if (typed && w != want) report("typed row", w, want);
        wheels_due.push_back(typed ? want : w);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain;
        while (wheels_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_moves(int count);
        logic signed [15:0] mx, my, cs;
        for (int n = 0; n < count; n++) begin
            mx = 16'($urandom);
            my = 16'($urandom);
            cs = 16'($urandom);
            case ($urandom_range(7))
                0: mx = 0;
                1: my = 0;
                2: cs = 0;
                3: begin
                    mx = 16'(int'($urandom_range(400)) - 200);
                    my = 16'($urandom_range(400));
                    cs = 16'($urandom_range(400));
                end
                default: ;
            endcase
            send_move(mx, my, cs, 1'b0, '0);
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_out_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        t_wheels exp_w;
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (wheels_due.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                exp_w = wheels_due.pop_front();
                if (o_left_forward !== exp_w.lfwd) report("left_forward", o_left_forward, exp_w.lfwd);
                if (o_left_speed !== exp_w.lspd) report("left_speed", o_left_speed, exp_w.lspd);
                if (o_right_forward !== exp_w.rfwd)
                    report("right_forward", o_right_forward, exp_w.rfwd);
                if (o_right_speed !== exp_w.rspd) report("right_speed", o_right_speed, exp_w.rspd);
            end
        end
        if (cycles > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    t_move_row moves[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{1'b0, 16'd100, 1'b0, 16'd100}},
        '{16'sd0, 16'sd5, 16'sd9, 1'b1, '{1'b1, 16'd100, 1'b1, 16'd100}},
        '{16'sd7, 16'sd0, 16'sd3, 1'b1, '{1'b0, 16'd100, 1'b0, 16'd100}},
        '{-16'sd32768, 16'sd0, 16'sd0, 1'b1, '{1'b0, 16'd100, 1'b0, 16'd100}},
        '{16'sd32767, 16'sd0, -16'sd32768, 1'b1, '{1'b0, 16'd100, 1'b0, 16'd100}},
        '{16'sd0, 16'sd32767, 16'sd32767, 1'b1, '{1'b1, 16'd100, 1'b1, 16'd100}},
        '{16'sd0, -16'sd32768, 16'sd5, 1'b0, '0},
        '{16'sd0, 16'sd4, -16'sd1, 1'b0, '0},
        '{16'sd100, 16'sd50, 16'sd0, 1'b0, '0},
        '{-16'sd100, 16'sd50, 16'sd0, 1'b0, '0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
        '{16'sd32767, -16'sd1, 16'sd32767, 1'b0, '0},
        '{-16'sd1, 16'sd1, 16'sd1, 1'b0, '0},
        '{16'sd1, 16'sd32767, 16'sd32767, 1'b0, '0},
        '{-16'sd300, -16'sd20, 16'sd400, 1'b0, '0},
        '{16'sd300, 16'sd200, 16'sd20, 1'b0, '0},
        '{16'sd21845, -16'sd21846, 16'sd1, 1'b0, '0}
    };

    initial begin
        angle_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                      128, 64, 32, 16, 8, 4, 2, 1, 0};
        mdl_max_speed = 100;
        mdl_turn_gain = 19661;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        foreach (moves[k]) send_move(moves[k].mx, moves[k].my, moves[k].cs,
                                     moves[k].typed, moves[k].want);
        drain();
        // extremes of both registers
        write_reg(REG_MAX_SPEED, 16'hffff);
        write_reg(REG_TURN_GAIN, 16'hffff);
        foreach (moves[k]) send_move(moves[k].mx, moves[k].my, moves[k].cs, 1'b0, '0);
        drain();
        write_reg(REG_MAX_SPEED, 16'd0);
        write_reg(REG_TURN_GAIN, 16'd0);
        send_idle_pct = 10;
        recv_idle_pct = 51;
        random_moves(200);
        drain();
        write_reg(REG_MAX_SPEED, 16'd1000);
        write_reg(REG_TURN_GAIN, 16'd19661);
        random_moves(400);
        // long hold-off on the output so the pipeline backs up
        hold_off = 200;
        random_moves(200);
        drain();
        write_reg(REG_MAX_SPEED, 16'($urandom));
        write_reg(REG_TURN_GAIN, 16'($urandom));
        send_idle_pct = 51;
        recv_idle_pct = 10;
        random_moves(600);
        drain();
        write_reg(REG_MAX_SPEED, 16'd100);
        write_reg(REG_TURN_GAIN, 16'd40000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_moves(600);
        drain();
        repeat (Latency + 4) @(negedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: differential_steer_mixer.f
design/dsm_pkg.sv
design/differential_steer_mixer.sv
sim/tb_differential_steer_mixer.sv
